// ----- rtl/uct_pkg.sv -----
// uct_pkg: shared types and constants for the URL component tagger.
// Depends on nothing; imported by every module of the block.
package uct_pkg;

	localparam int unsigned MID_DEPTH = 4;
	localparam int unsigned MID_AW    = $clog2(MID_DEPTH);
	localparam int unsigned OUT_DEPTH = 2;
	localparam int unsigned OUT_AW    = $clog2(OUT_DEPTH);

	localparam logic [7:0] CH_COLON = 8'h3A;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_QUEST = 8'h3F;
	localparam logic [7:0] CH_HASH  = 8'h23;

	localparam logic [2:0] TAG_SCHEME = 3'd0;
	localparam logic [2:0] TAG_HOST   = 3'd1;
	localparam logic [2:0] TAG_PORT   = 3'd2;
	localparam logic [2:0] TAG_PATH   = 3'd3;
	localparam logic [2:0] TAG_QUERY  = 3'd4;
	localparam logic [2:0] TAG_FRAG   = 3'd5;
	localparam logic [2:0] TAG_DROP   = 3'd6;

	localparam logic [1:0] ERR_NONE     = 2'd0;
	localparam logic [1:0] ERR_SLASH    = 2'd1;
	localparam logic [1:0] ERR_NOCOLON  = 2'd2;
	localparam logic [1:0] ERR_NOSLASH2 = 2'd3;

	typedef enum logic [2:0] {
		CL_COLON,
		CL_SLASH,
		CL_QUEST,
		CL_HASH,
		CL_OTHER
	} char_class_t;

	typedef enum logic [3:0] {
		PH_SCHEME = 4'd0,
		PH_SLASH1 = 4'd1,
		PH_SLASH2 = 4'd2,
		PH_HOST   = 4'd3,
		PH_PORT   = 4'd4,
		PH_PATH   = 4'd5,
		PH_QUERY  = 4'd6,
		PH_FRAG   = 4'd7,
		PH_ERROR  = 4'd8
	} phase_t;

	typedef struct packed {
		char_class_t cls;
		logic [7:0]  ch;
		logic        last;
	} front_word_t;

	typedef struct packed {
		logic [7:0] ch;
		logic [2:0] tag;
		logic       last;
		logic [1:0] err;
	} result_word_t;

endpackage

// ----- rtl/url_component_tagger_unit.sv -----
// url_component_tagger_unit: top level of the URL component tagger.
// Depends on uct_pkg, uct_front, uct_queue and uct_back.
//
// Takes one URL byte per cycle while full is low and returns one word per
// byte: the byte, its component tag (scheme, host, port, path, query,
// fragment or dropped byte), the last mark and the sticky error code, which
// is final on the word that carries last_out. The sustained rate is one byte
// per clock when no side stalls; the phase register of the back-end state
// machine is updated once per byte. A byte passes the input register and the
// middle queue into the result queue, whose head drives the result ports.
// Each side stalls independently: a four-word queue sits between
// classification and parsing, and a two-word queue holds results.
module url_component_tagger_unit import uct_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	output logic       full,
	input  logic [7:0] char_in,
	input  logic       last_in,
	input  logic       pop,
	output logic       empty,
	output logic [7:0] char_out,
	output logic [2:0] field_tag,
	output logic       last_out,
	output logic [1:0] error_code
);

	logic        fw_valid;
	front_word_t fw_word;
	logic        mq_full;
	logic        mq_empty;
	logic        mq_rd;
	front_word_t mq_word;

	uct_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.char_in    (char_in),
		.last_in    (last_in),
		.word_valid (fw_valid),
		.word       (fw_word),
		.word_full  (mq_full)
	);

	uct_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (fw_valid),
		.wr_word (fw_word),
		.q_full  (mq_full),
		.rd_en   (mq_rd),
		.rd_word (mq_word),
		.q_empty (mq_empty)
	);

	uct_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_empty    (mq_empty),
		.q_word     (mq_word),
		.q_rd       (mq_rd),
		.pop        (pop),
		.empty      (empty),
		.char_out   (char_out),
		.field_tag  (field_tag),
		.last_out   (last_out),
		.error_code (error_code)
	);

endmodule

// ----- rtl/uct_front.sv -----
// uct_front: input register stage; classifies each byte against the delimiters.
// Depends on uct_pkg.
module uct_front import uct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  char_in,
	input  logic        last_in,
	output logic        word_valid,
	output front_word_t word,
	input  logic        word_full
);

	logic        valid_s1;
	front_word_t word_s1;
	logic        accept;
	logic        send;
	char_class_t cls_c;

	always_comb begin
		case (char_in)
			CH_COLON: cls_c = CL_COLON;
			CH_SLASH: cls_c = CL_SLASH;
			CH_QUEST: cls_c = CL_QUEST;
			CH_HASH:  cls_c = CL_HASH;
			default:  cls_c = CL_OTHER;
		endcase
	end

	assign send   = valid_s1 && !word_full;
	assign full   = valid_s1 && word_full;
	assign accept = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (send) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			word_s1 <= '{cls: cls_c, ch: char_in, last: last_in};
		end
	end

	assign word_valid = send;
	assign word       = word_s1;

endmodule

// ----- rtl/uct_queue.sv -----
// uct_queue: short queue of classified words between front and back.
// Depends on uct_pkg.
module uct_queue import uct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  front_word_t wr_word,
	output logic        q_full,
	input  logic        rd_en,
	output front_word_t rd_word,
	output logic        q_empty
);

	front_word_t        mem [MID_DEPTH];
	logic [MID_AW-1:0]  wr_ptr_q;
	logic [MID_AW-1:0]  rd_ptr_q;
	logic [MID_AW:0]    cnt_q;
	logic               do_wr;
	logic               do_rd;

	assign q_full  = (cnt_q == (MID_AW+1)'(MID_DEPTH));
	assign q_empty = (cnt_q == '0);
	assign do_wr   = wr_en && !q_full;
	assign do_rd   = rd_en && !q_empty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({do_wr, do_rd})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem[wr_ptr_q] <= wr_word;
		end
	end

	assign rd_word = mem[rd_ptr_q];

endmodule

// ----- rtl/uct_back.sv -----
// uct_back: parse state machine and result queue.
// Depends on uct_pkg; takes words from uct_queue.
module uct_back import uct_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        q_empty,
	input  front_word_t q_word,
	output logic        q_rd,
	input  logic        pop,
	output logic        empty,
	output logic [7:0]  char_out,
	output logic [2:0]  field_tag,
	output logic        last_out,
	output logic [1:0]  error_code
);

	phase_t             phase_q;
	logic [1:0]         err_q;
	phase_t             phase_d;
	phase_t             phase_step;
	logic [1:0]         err_d;
	logic [1:0]         err_step;
	logic [2:0]         tag_c;

	result_word_t       out_mem [OUT_DEPTH];
	logic [OUT_AW-1:0]  out_wr_ptr_q;
	logic [OUT_AW-1:0]  out_rd_ptr_q;
	logic [OUT_AW:0]    out_cnt_q;
	logic               out_pop;
	logic               step;
	result_word_t       res_c;

	// next state
	always_comb begin
		phase_step = phase_q;
		err_step   = err_q;
		case (phase_q)
			PH_SCHEME: begin
				if (q_word.cls == CL_COLON) begin
					phase_step = PH_SLASH1;
				end else if (q_word.cls == CL_SLASH) begin
					phase_step = PH_ERROR;
					err_step   = (err_q == ERR_NONE) ? ERR_SLASH : err_q;
				end
			end
			PH_SLASH1: begin
				if (q_word.cls == CL_SLASH) begin
					phase_step = PH_SLASH2;
				end else begin
					phase_step = PH_ERROR;
					err_step   = (err_q == ERR_NONE) ? ERR_NOSLASH2 : err_q;
				end
			end
			PH_SLASH2: begin
				if (q_word.cls == CL_SLASH) begin
					phase_step = PH_HOST;
				end else begin
					phase_step = PH_ERROR;
					err_step   = (err_q == ERR_NONE) ? ERR_NOSLASH2 : err_q;
				end
			end
			PH_HOST: begin
				if (q_word.cls == CL_COLON) begin
					phase_step = PH_PORT;
				end else if (q_word.cls == CL_SLASH) begin
					phase_step = PH_PATH;
				end
			end
			PH_PORT: begin
				if (q_word.cls == CL_SLASH) begin
					phase_step = PH_PATH;
				end
			end
			PH_PATH: begin
				if (q_word.cls == CL_QUEST) begin
					phase_step = PH_QUERY;
				end else if (q_word.cls == CL_HASH) begin
					phase_step = PH_FRAG;
				end
			end
			PH_QUERY: begin
				if (q_word.cls == CL_HASH) begin
					phase_step = PH_FRAG;
				end
			end
			PH_FRAG: begin
				phase_step = PH_FRAG;
			end
			default: begin
				phase_step = PH_ERROR;
			end
		endcase

		// end-of-URL checks
		if (q_word.last) begin
			if (phase_step == PH_SCHEME) begin
				err_step = (err_step == ERR_NONE) ? ERR_NOCOLON : err_step;
			end else if (phase_step inside {PH_SLASH1, PH_SLASH2}) begin
				err_step = (err_step == ERR_NONE) ? ERR_NOSLASH2 : err_step;
			end
		end

		if (q_word.last) begin
			phase_d = PH_SCHEME;
			err_d   = ERR_NONE;
		end else begin
			phase_d = phase_step;
			err_d   = err_step;
		end
	end

	// outputs
	always_comb begin
		tag_c = TAG_DROP;
		case (phase_q)
			PH_SCHEME: begin
				if (!(q_word.cls inside {CL_COLON, CL_SLASH})) begin
					tag_c = TAG_SCHEME;
				end
			end
			PH_HOST: begin
				if (!(q_word.cls inside {CL_COLON, CL_SLASH})) begin
					tag_c = TAG_HOST;
				end
			end
			PH_PORT: begin
				if (q_word.cls != CL_SLASH) begin
					tag_c = TAG_PORT;
				end
			end
			PH_PATH: begin
				if (!(q_word.cls inside {CL_QUEST, CL_HASH})) begin
					tag_c = TAG_PATH;
				end
			end
			PH_QUERY: begin
				if (q_word.cls != CL_HASH) begin
					tag_c = TAG_QUERY;
				end
			end
			PH_FRAG: begin
				tag_c = TAG_FRAG;
			end
			default: begin
				tag_c = TAG_DROP;
			end
		endcase
		res_c = '{ch: q_word.ch, tag: tag_c, last: q_word.last, err: err_step};
	end

	assign empty   = (out_cnt_q == '0);
	assign out_pop = pop && !empty;
	assign step    = !q_empty && ((out_cnt_q != (OUT_AW+1)'(OUT_DEPTH)) || out_pop);
	assign q_rd    = step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q      <= PH_SCHEME;
			err_q        <= ERR_NONE;
			out_wr_ptr_q <= '0;
			out_rd_ptr_q <= '0;
			out_cnt_q    <= '0;
		end else begin
			if (step) begin
				phase_q      <= phase_d;
				err_q        <= err_d;
				out_wr_ptr_q <= out_wr_ptr_q + 1'b1;
			end
			if (out_pop) begin
				out_rd_ptr_q <= out_rd_ptr_q + 1'b1;
			end
			case ({step, out_pop})
				2'b10:   out_cnt_q <= out_cnt_q + 1'b1;
				2'b01:   out_cnt_q <= out_cnt_q - 1'b1;
				default: out_cnt_q <= out_cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			out_mem[out_wr_ptr_q] <= res_c;
		end
	end

	assign char_out   = out_mem[out_rd_ptr_q].ch;
	assign field_tag  = out_mem[out_rd_ptr_q].tag;
	assign last_out   = out_mem[out_rd_ptr_q].last;
	assign error_code = out_mem[out_rd_ptr_q].err;

endmodule
